FILE: rtl/core/length_checked_frame_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_CHECKED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_CHECKED_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

`define LCFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define LCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define LCFD_ASSERT(label, clk, rst_n, prop)

`define LCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/lcfd_pkg.sv
`default_nettype none

package lcfd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_LCS  = 3'd2,
        PH_DATA = 3'd3,
        PH_CHK  = 3'd4,
        PH_POST = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_HDR_ERR = 2'd1,
        KIND_ACK     = 2'd2
    } t_kind;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] ACK_LEN    = 8'h00;
    localparam logic [7:0] ACK_LCS    = 8'hFF;

endpackage

`default_nettype wire

FILE: rtl/core/length_checked_frame_deframer.sv
// A byte accepted is held in the input register, and its result then goes to the result register.
// Throughput: one byte per clock while the result register is empty or i_out_ready is high.
// The result register may hold a transaction while the next byte is accepted.
// Reset is synchronous and active low: phase returns to hunting for the start
// byte, the length counters clear and both pipeline registers are emptied.
`default_nettype none

module length_checked_frame_deframer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output lcfd_pkg::t_kind           o_kind,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last_of_frame
);
    import lcfd_pkg::*;

    `include "length_checked_frame_deframer_macros.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    t_phase     r_phase, n_phase;
    logic [7:0] r_frame_length, n_frame_length;
    logic [7:0] r_bytes_left, n_bytes_left;

    logic       r_out_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_payload, n_payload;
    logic       r_last, n_last;
    logic       n_has_result;

    logic       w_adv;
    logic [7:0] w_lcs_sum;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_lcs_sum  = r_frame_length + r_in_byte;

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_bytes_left   = r_bytes_left;
        n_has_result   = 1'b0;
        n_kind         = KIND_PAYLOAD;
        n_payload      = 8'd0;
        n_last         = 1'b0;
        unique case (r_phase)
            PH_LEN: begin
                n_frame_length = r_in_byte;
                n_phase        = PH_LCS;
            end
            PH_LCS: begin
                if (r_frame_length == ACK_LEN && r_in_byte == ACK_LCS) begin
                    n_phase      = PH_HUNT;
                    n_has_result = 1'b1;
                    n_kind       = KIND_ACK;
                end else if (w_lcs_sum != 8'd0) begin
                    n_phase      = PH_HUNT;
                    n_has_result = 1'b1;
                    n_kind       = KIND_HDR_ERR;
                end else begin
                    n_bytes_left = r_frame_length;
                    n_phase      = (r_frame_length == 8'd0) ? PH_CHK : PH_DATA;
                end
            end
            PH_DATA: begin
                n_has_result = 1'b1;
                n_payload    = r_in_byte;
                if (r_bytes_left <= 8'd1) begin
                    n_bytes_left = 8'd0;
                    n_phase      = PH_CHK;
                    n_last       = 1'b1;
                end else begin
                    n_bytes_left = r_bytes_left - 8'd1;
                end
            end
            PH_CHK: begin
                n_phase = PH_POST;
            end
            PH_POST: begin
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = (r_in_byte == START_BYTE) ? PH_LEN : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_HUNT;
            r_frame_length <= 8'd0;
            r_bytes_left   <= 8'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_phase        <= n_phase;
                r_frame_length <= n_frame_length;
                r_bytes_left   <= n_bytes_left;
                r_out_valid    <= n_has_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_adv && n_has_result) begin
            r_kind    <= n_kind;
            r_payload <= n_payload;
            r_last    <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_payload_byte  = r_payload;
    assign o_last_of_frame = r_last;

    `LCFD_ASSERT(a_non_payload_clean, i_clk, i_rst_n,
        (r_out_valid && r_kind != KIND_PAYLOAD) |-> (r_payload == 8'd0 && !r_last))
    `LCFD_ASSERT(a_data_has_bytes_left, i_clk, i_rst_n,
        (r_phase == PH_DATA) |-> (r_bytes_left != 8'd0))
    `LCFD_ASSERT_NEXT(a_error_resumes_hunt, i_clk, i_rst_n,
        w_adv && n_has_result && n_kind != KIND_PAYLOAD, r_phase == PH_HUNT)
    `LCFD_ASSERT_NEXT(a_last_goes_to_checksum, i_clk, i_rst_n,
        w_adv && n_has_result && n_last, r_phase == PH_CHK && r_out_valid)

endmodule

`default_nettype wire
